// ===== rtl/csq_pkg.sv =====
// ----------------------------------------------------------------------------
// csq_pkg: shared types and codes for the counting semaphore block
// Operation and status codes, register indexes, stream layouts, the
// controller state type and the command/status bundles.
// ----------------------------------------------------------------------------
package csq_pkg;

   // stream word widths (fields packed from bit 0 up, padded to bytes)
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 32;

   localparam int FUNC_W   = 3;
   localparam int ID_W     = 8;
   localparam int PRIO_W   = 8;
   localparam int TMO_W    = 17;
   localparam int STATUS_W = 3;
   localparam int CNT_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_WAIT    = 3'd0;
   localparam logic [FUNC_W-1:0] FN_POLL    = 3'd1;
   localparam logic [FUNC_W-1:0] FN_TWAIT   = 3'd2;
   localparam logic [FUNC_W-1:0] FN_SIGNAL  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_USIGNAL = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PAR   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TMOUT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVR   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INIT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WAKE_ORDER = 2'd2;

   // controller states
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_OUT    = 5'b10000
   } csq_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request word
      logic exec;        // run a non-waking operation
      logic scan_init;   // clear the selection scan
      logic scan_step;   // one scan step over the wait queue
      logic shift_init;  // start closing the gap at the picked entry
      logic shift_step;  // move one entry down
      logic wake_done;   // drop one waiter and record the woken task
      logic emit;        // load the response register
   } csq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic wake_needed; // signal with at least one waiter
      logic scan_done;
      logic shift_done;
      logic rsp_busy;    // response register still holds an untaken word
   } csq_stat_type;

endpackage

// ===== rtl/csq_ctrl.sv =====
// ----------------------------------------------------------------------------
// csq_ctrl: operation sequencer
// Accepts one request word at a time and steps the datapath through
// decode, waiter selection, queue compaction and response hand-off.
// ----------------------------------------------------------------------------
module csq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  csq_pkg::csq_stat_type stat,
   output csq_pkg::csq_cmd_type  cmd
);
   import csq_pkg::*;

   csq_state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // no word is taken while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.wake_needed) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_OUT;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_done) begin
               cmd.wake_done = 1'b1;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (!stat.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/csq_dp.sv =====
// ----------------------------------------------------------------------------
// csq_dp: semaphore datapath
// Holds the count, the settings, the wait queue memories, the selection
// scan, queue compaction and the response register.
// ----------------------------------------------------------------------------
module csq_dp #(
   parameter int WAIT_DEPTH = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [csq_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [csq_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [csq_pkg::REQ_TDATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [csq_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  csq_pkg::csq_cmd_type                 cmd,
   output csq_pkg::csq_stat_type                stat
);
   import csq_pkg::*;

   localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int TW = $clog2(WAIT_DEPTH + 1);
   localparam int WW = TW + 1;
   localparam logic [COUNT_BITS-1:0] CNT_ONES = '1;

   // settings and state
   logic [CNT_W-1:0]      max_ff;
   logic                  order_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TW-1:0]         total_ff;

   // captured request
   logic [FUNC_W-1:0]     func_ff;
   logic [ID_W-1:0]       id_ff;
   logic [PRIO_W-1:0]     prio_ff;
   logic signed [TMO_W-1:0] tmo_ff;

   // wait queue
   logic [ID_W-1:0]   id_mem   [WAIT_DEPTH];
   logic [PRIO_W-1:0] prio_mem [WAIT_DEPTH];
   logic [WW-1:0]     rd_addr_wide;
   logic [AW-1:0]     rd_addr;
   logic [ID_W-1:0]   rd_id_ff;
   logic [PRIO_W-1:0] rd_prio_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [ID_W-1:0]   mem_wid;
   logic [PRIO_W-1:0] mem_wprio;

   // scan and compaction
   logic [TW-1:0]     idx_ff;
   logic              chk_ff;
   logic [AW-1:0]     chk_idx_ff;
   logic [AW-1:0]     pick_ff;
   logic [ID_W-1:0]   best_id_ff;
   logic [PRIO_W-1:0] best_prio_ff;
   logic [TW-1:0]     limit;
   logic              scan_issue;
   logic              shift_more;

   // result fields waiting for the response register
   logic [STATUS_W-1:0] res_status_ff;
   logic                res_gr_ff, res_enq_ff, res_wv_ff;
   logic [ID_W-1:0]     res_wt_ff;

   // response register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic                out_gr_ff, out_enq_ff, out_wv_ff;
   logic [ID_W-1:0]     out_wt_ff;
   logic [CNT_W-1:0]    out_cnt_ff;

   // non-waking operation results
   logic [31:0]         cnt32, max32, ones32;
   logic                try_take, may_queue;
   logic [STATUS_W-1:0] ex_status;
   logic                ex_gr, ex_enq;
   logic [COUNT_BITS-1:0] ex_count;

   assign cnt32  = 32'(count_ff);
   assign max32  = 32'(max_ff);
   assign ones32 = 32'(CNT_ONES);

   always_comb begin
      try_take  = 1'b0;
      may_queue = 1'b0;
      ex_status = ST_OK;
      ex_gr     = 1'b0;
      ex_enq    = 1'b0;
      ex_count  = count_ff;
      case (func_ff)
         FN_WAIT: begin
            try_take  = 1'b1;
            may_queue = 1'b1;
         end
         FN_POLL: begin
            try_take = 1'b1;
         end
         FN_TWAIT: begin
            if (tmo_ff < -17'sd1) begin
               ex_status = ST_PAR;
            end else begin
               try_take  = 1'b1;
               may_queue = (tmo_ff != 17'sd0);
            end
         end
         FN_SIGNAL: begin
            if ((cnt32 == 32'd0 || cnt32 < max32) && cnt32 < ones32) begin
               ex_count = count_ff + COUNT_BITS'(1);
            end else begin
               ex_status = ST_OVR;
            end
         end
         FN_USIGNAL: begin
            if (cnt32 < ones32) begin
               ex_count = count_ff + COUNT_BITS'(1);
            end
         end
         default: begin
            ex_status = ST_PAR;
         end
      endcase
      if (try_take) begin
         if (count_ff != '0) begin
            ex_count = count_ff - COUNT_BITS'(1);
            ex_gr    = 1'b1;
         end else if (!may_queue) begin
            ex_status = ST_TMOUT;
         end else if (total_ff >= TW'(WAIT_DEPTH)) begin
            ex_status = ST_FULL;
         end else begin
            ex_enq = 1'b1;
         end
      end
   end

   // scan runs over the whole queue in priority mode, only the head otherwise
   assign limit      = order_ff ? total_ff : TW'(1);
   assign scan_issue = (idx_ff < limit);
   assign shift_more = ((WW'(idx_ff) + WW'(1)) < WW'(total_ff));

   // read address: scan index, entry after the pick, or two ahead while shifting
   always_comb begin
      if (cmd.shift_init) begin
         rd_addr_wide = WW'(pick_ff) + WW'(1);
      end else if (cmd.shift_step) begin
         rd_addr_wide = WW'(idx_ff) + WW'(2);
      end else begin
         rd_addr_wide = WW'(idx_ff);
      end
      rd_addr = (rd_addr_wide < WW'(WAIT_DEPTH)) ? AW'(rd_addr_wide) : '0;
   end

   // single write port: enqueue or compaction move
   always_comb begin
      mem_we    = 1'b0;
      mem_wa    = AW'(total_ff);
      mem_wid   = id_ff;
      mem_wprio = prio_ff;
      if (cmd.exec && ex_enq) begin
         mem_we = 1'b1;
      end else if (cmd.shift_step && shift_more) begin
         mem_we    = 1'b1;
         mem_wa    = AW'(idx_ff);
         mem_wid   = rd_id_ff;
         mem_wprio = rd_prio_ff;
      end
   end

   // wait queue memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         id_mem[mem_wa]   <= mem_wid;
         prio_mem[mem_wa] <= mem_wprio;
      end
      rd_id_ff   <= id_mem[rd_addr];
      rd_prio_ff <= prio_mem[rd_addr];
   end

   // settings, count and queue fill
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= CNT_W'(1);
         order_ff <= 1'b0;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_INIT_COUNT: count_ff <= COUNT_BITS'(csr_wdata);
               REG_MAX_COUNT:  max_ff   <= csr_wdata;
               REG_WAKE_ORDER: order_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (cmd.exec) begin
            count_ff <= ex_count;
            if (ex_enq) begin
               total_ff <= total_ff + TW'(1);
            end
         end
         if (cmd.wake_done) begin
            total_ff <= total_ff - TW'(1);
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tdata[2:0];
         id_ff   <= req_tdata[10:3];
         prio_ff <= req_tdata[18:11];
         tmo_ff  <= $signed(req_tdata[35:19]);
      end
   end

   // selection scan and compaction index
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (cmd.scan_init) begin
            idx_ff <= '0;
            chk_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            chk_ff <= scan_issue;
            if (scan_issue) begin
               idx_ff <= idx_ff + TW'(1);
            end
         end
         if (cmd.shift_init) begin
            idx_ff <= TW'(pick_ff);
         end
         if (cmd.shift_step && shift_more) begin
            idx_ff <= idx_ff + TW'(1);
         end
      end
   end

   // best candidate so far; strict compare keeps the earliest on a tie
   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         if (scan_issue) begin
            chk_idx_ff <= AW'(idx_ff);
         end
         if (chk_ff && (chk_idx_ff == '0 || rd_prio_ff < best_prio_ff)) begin
            best_prio_ff <= rd_prio_ff;
            best_id_ff   <= rd_id_ff;
            pick_ff      <= chk_idx_ff;
         end
      end
   end

   // result fields
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_status_ff <= ex_status;
         res_gr_ff     <= ex_gr;
         res_enq_ff    <= ex_enq;
         res_wv_ff     <= 1'b0;
         res_wt_ff     <= '0;
      end
      if (cmd.wake_done) begin
         res_status_ff <= ST_OK;
         res_gr_ff     <= 1'b0;
         res_enq_ff    <= 1'b0;
         res_wv_ff     <= 1'b1;
         res_wt_ff     <= best_id_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_status_ff <= res_status_ff;
         out_gr_ff     <= res_gr_ff;
         out_enq_ff    <= res_enq_ff;
         out_wv_ff     <= res_wv_ff;
         out_wt_ff     <= res_wt_ff;
         out_cnt_ff    <= CNT_W'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_cnt_ff, out_wt_ff, out_wv_ff, out_enq_ff,
                        out_gr_ff, out_status_ff};

   // status to the sequencer
   assign stat.wake_needed = (func_ff == FN_SIGNAL || func_ff == FN_USIGNAL) &&
                             (total_ff != '0);
   assign stat.scan_done   = !scan_issue && !chk_ff;
   assign stat.shift_done  = !shift_more;
   assign stat.rsp_busy    = rsp_valid_ff && !rsp_tready;

endmodule

// ===== rtl/counting_semaphore_wait_queue_top.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_top: counting semaphore with wait queue
// Keeps a count and a bounded queue of waiting tasks; waits take a unit or
// queue the caller, signals release the oldest or most urgent waiter or else add a unit.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | contents
//  req     | in  | req_tvalid/req_tready | one operation word
//  rsp     | out | rsp_tvalid/rsp_tready | one result word per operation
//  csr     | in  | csr_we                | register write, no read-back
//
// Wait, poll, timed wait and signals without waiters pass from decode
// straight to the response. A signal with waiters first scans the queue
// (only the head in arrival order, every entry in priority order) and then
// closes the gap behind the picked slot: the wait queue memory has one read
// and one write port, so the scan and the gap-closing move go one entry per
// cycle. Reset is synchronous, holds req_tready low and needs no clearing
// pass. A new word is accepted while the previous result waits on
// rsp_tready; a stalled response holds the sequencer.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_top #(
   parameter int WAIT_DEPTH = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [csq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csq_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // func[2:0], task_id[10:3], task_priority[18:11], timeout_ms[35:19]
   input  logic [csq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[2:0], granted[3], enqueued[4], woken_valid[5], woken_task[13:6],
   // count_now[29:14]
   output logic [csq_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import csq_pkg::*;

   csq_cmd_type  cmd;
   csq_stat_type stat;

   csq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   csq_dp #(
      .WAIT_DEPTH (WAIT_DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== tb/semaphore_result_checker.sv =====
// ----------------------------------------------------------------------------
// semaphore_result_checker: predicts and checks semaphore result words
// Tracks register writes and accepted request words, keeps its own copy of
// the count and the wait queue, and compares every response word against
// the oldest predicted result, field by field.
// ----------------------------------------------------------------------------
module semaphore_result_checker #(
   parameter int WAIT_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [csq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [csq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // func[2:0], task_id[10:3], task_priority[18:11], timeout_ms[35:19]
   input  logic [csq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0], granted[3], enqueued[4], woken_valid[5], woken_task[13:6],
   // count_now[29:14]
   input  logic [csq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                              mismatches,
   output int                              outstanding
);
   import csq_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                granted;
      logic                enqueued;
      logic                woken_valid;
      logic [ID_W-1:0]     woken_task;
      logic [CNT_W-1:0]    count_now;
   } sem_result_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } waiter_type;

   // predictor state
   logic [CNT_W-1:0] sem_count      = '0;
   logic [CNT_W-1:0] cfg_max_count  = 16'd1;
   logic             cfg_wake_order = 1'b0;
   waiter_type       waiters[$];
   sem_result_type   expected_results[$];
   int               err_total = 0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Apply one request word to the semaphore copy, return its result
   function automatic sem_result_type predict_semaphore_op(logic [REQ_TDATA_W-1:0] word);
      logic [FUNC_W-1:0]        fn;
      logic [ID_W-1:0]          id;
      logic [PRIO_W-1:0]        prio;
      logic signed [TMO_W-1:0]  tmo;
      logic                     try_take;
      logic                     may_queue;
      int                       pick;
      int                       i;
      sem_result_type           r;
      fn   = word[FUNC_W-1:0];
      id   = word[FUNC_W +: ID_W];
      prio = word[FUNC_W+ID_W +: PRIO_W];
      tmo  = word[FUNC_W+ID_W+PRIO_W +: TMO_W];
      r         = '0;
      r.status  = ST_OK;
      try_take  = 1'b0;
      may_queue = 1'b0;
      case (fn)
         FN_WAIT: begin
            try_take  = 1'b1;
            may_queue = 1'b1;
         end
         FN_POLL: begin
            try_take = 1'b1;
         end
         FN_TWAIT: begin
            // anything below forever is rejected, even with a unit free
            if (tmo < -1) begin
               r.status = ST_PAR;
            end else begin
               try_take  = 1'b1;
               may_queue = (tmo != 0);
            end
         end
         FN_SIGNAL, FN_USIGNAL: begin
            if (waiters.size() > 0) begin
               // oldest waiter, or lowest priority number with earliest on a tie
               pick = 0;
               if (cfg_wake_order) begin
                  for (i = 1; i < waiters.size(); i++)
                     if (waiters[i].prio < waiters[pick].prio) pick = i;
               end
               r.woken_valid = 1'b1;
               r.woken_task  = waiters[pick].id;
               waiters.delete(pick);
            end else if (fn == FN_USIGNAL) begin
               if (sem_count != '1) sem_count++;
            end else if ((sem_count == 0 || sem_count < cfg_max_count) &&
                         sem_count != '1) begin
               sem_count++;
            end else begin
               r.status = ST_OVR;
            end
         end
         default: begin
            r.status = ST_PAR;
         end
      endcase

      if (try_take) begin
         if (sem_count != 0) begin
            sem_count--;
            r.granted = 1'b1;
         end else if (!may_queue) begin
            r.status = ST_TMOUT;
         end else if (waiters.size() >= WAIT_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            waiters.push_back(waiter_type'{id, prio});
            r.enqueued = 1'b1;
         end
      end
      r.count_now = sem_count;
      return r;
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         err_total++;
         if (err_total <= 10)
            $display("%0t: mismatch on %s: expected %0d, got %0d",
                     $realtime, field, want, got);
      end
   endtask

   // Watch the channels; responses are retired before new requests are added
   always @(posedge clock) begin : watch
      sem_result_type got;
      sem_result_type want;
      if (reset) begin
         sem_count      = '0;
         cfg_max_count  = 16'd1;
         cfg_wake_order = 1'b0;
         waiters.delete();
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_INIT_COUNT: sem_count      = csr_wdata;
               REG_MAX_COUNT:  cfg_max_count  = csr_wdata;
               REG_WAKE_ORDER: cfg_wake_order = csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got             = '0;
            got.status      = rsp_tdata[2:0];
            got.granted     = rsp_tdata[3];
            got.enqueued    = rsp_tdata[4];
            got.woken_valid = rsp_tdata[5];
            got.woken_task  = rsp_tdata[13:6];
            got.count_now   = rsp_tdata[29:14];
            if (expected_results.size() == 0) begin
               err_total++;
               if (err_total <= 10)
                  $display("%0t: response word 0x%h with no request outstanding",
                           $realtime, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               check_field("status",      want.status,      got.status);
               check_field("granted",     want.granted,     got.granted);
               check_field("enqueued",    want.enqueued,    got.enqueued);
               check_field("woken_valid", want.woken_valid, got.woken_valid);
               check_field("woken_task",  want.woken_task,  got.woken_task);
               check_field("count_now",   want.count_now,   got.count_now);
            end
         end

         if (req_tvalid && req_tready)
            expected_results.push_back(predict_semaphore_op(req_tdata));
      end
      outstanding <= expected_results.size();
      mismatches  <= err_total;
   end

endmodule

// ===== tb/counting_semaphore_wait_queue_top_tb.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_top_tb: semaphore block testbench
// Drives directed and random semaphore operations under several register
// settings and idle patterns; a checker module predicts every result word.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue_top_tb;
   import csq_pkg::*;

   localparam int PHASE_COUNT = 6;
   localparam int PHASE_ITEMS = 180;

   // codes the block does not know
   localparam logic [FUNC_W-1:0] FN_BAD_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FN_BAD_LAST  = 3'd7;

   // notable timeout values (17-bit two's complement)
   localparam logic [TMO_W-1:0] TMO_FOREVER  = 17'h1FFFF;
   localparam logic [TMO_W-1:0] TMO_POLL     = 17'h00000;
   localparam logic [TMO_W-1:0] TMO_BAD      = 17'h1FFFE;
   localparam logic [TMO_W-1:0] TMO_MOST_NEG = 17'h10000;
   localparam logic [TMO_W-1:0] TMO_LONGEST  = 17'h0FFFF;

   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX, BURST_NOISE} burst_kind_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = REG_INIT_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // func[2:0], task_id[10:3], task_priority[18:11], timeout_ms[35:19]
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // status[2:0], granted[3], enqueued[4], woken_valid[5], woken_task[13:6],
   // count_now[29:14]
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches;
   int outstanding;

   counting_semaphore_wait_queue_top uut (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   semaphore_result_checker checker_i (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .mismatches, .outstanding
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random
   always @(posedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);

   function automatic logic [REQ_TDATA_W-1:0] pack_req(logic [FUNC_W-1:0] fn,
                                                       logic [ID_W-1:0] id,
                                                       logic [PRIO_W-1:0] prio,
                                                       logic [TMO_W-1:0] tmo);
      return REQ_TDATA_W'({tmo, prio, id, fn});
   endfunction

   function automatic logic [TMO_W-1:0] pick_timeout();
      case ($urandom_range(5))
         0:       return TMO_FOREVER;
         1:       return TMO_POLL;
         2:       return TMO_BAD;
         3:       return TMO_W'($urandom_range(65535, 1));
         default: return TMO_W'($urandom);
      endcase
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] random_op(burst_kind_type kind);
      logic [FUNC_W-1:0] fn;
      logic [PRIO_W-1:0] prio;
      int                roll;
      roll = $urandom_range(99);
      case (kind)
         BURST_FILL:
            fn = (roll < 60) ? FN_WAIT : (roll < 85) ? FN_TWAIT :
                 (roll < 95) ? FN_POLL : FN_SIGNAL;
         BURST_DRAIN:
            fn = (roll < 55) ? FN_SIGNAL : (roll < 85) ? FN_USIGNAL : FN_WAIT;
         BURST_MIX:
            fn = FUNC_W'($urandom_range(FN_USIGNAL));
         default:
            fn = FUNC_W'($urandom);
      endcase
      // few distinct priorities half the time, so ties happen
      prio = $urandom_range(1) ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
      return pack_req(fn, ID_W'($urandom), prio, pick_timeout());
   endfunction

   // Present one word, with a random gap before it, and wait for acceptance
   task automatic send_word(input logic [REQ_TDATA_W-1:0] word);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and wait until every result word has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Write all three registers back to back; block must be idle
   task automatic apply_setting(input logic [CNT_W-1:0] init_v,
                                input logic [CNT_W-1:0] max_v,
                                input logic order_v);
      csr_we    <= 1'b1;
      csr_index <= REG_MAX_COUNT;
      csr_wdata <= max_v;
      @(posedge clock);
      csr_index <= REG_WAKE_ORDER;
      csr_wdata <= CSR_DATA_W'(order_v);
      @(posedge clock);
      csr_index <= REG_INIT_COUNT;
      csr_wdata <= init_v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Bursts that fill or drain the wait queue, plus mixed and noise bursts
   task automatic run_random(input int n_items);
      int             sent;
      int             roll;
      burst_kind_type kind;
      sent = 0;
      while (sent < n_items) begin
         roll = $urandom_range(99);
         kind = (roll < 35) ? BURST_FILL : (roll < 70) ? BURST_DRAIN :
                (roll < 90) ? BURST_MIX : BURST_NOISE;
         repeat ($urandom_range(24, 1)) begin
            send_word(random_op(kind));
            sent++;
         end
         if ($urandom_range(29) == 0) wait_drain();
      end
   endtask

   // Run limit
   initial begin
      #8_000_000;
      $display("counting_semaphore_wait_queue_top_tb failed");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      int p;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings are count 0, max 1, arrival order
      send_word(pack_req(FN_POLL,      8'd1,   8'd1,   TMO_POLL));     // timeout
      send_word(pack_req(FN_TWAIT,     8'd2,   8'd2,   TMO_POLL));     // timeout
      send_word(pack_req(FN_TWAIT,     8'd3,   8'd3,   TMO_BAD));      // bad parameter
      send_word(pack_req(FN_TWAIT,     8'd4,   8'd4,   TMO_MOST_NEG)); // bad parameter
      send_word(pack_req(FN_BAD_FIRST, 8'd5,   8'd5,   TMO_POLL));
      send_word(pack_req(FN_BAD_FIRST + 3'd1, 8'd6, 8'd6, TMO_FOREVER));
      send_word(pack_req(FN_BAD_LAST,  8'hFF,  8'hFF,  TMO_FOREVER));
      send_word(pack_req(FN_SIGNAL,    8'd0,   8'd0,   TMO_POLL));     // count to 1
      send_word(pack_req(FN_SIGNAL,    8'd0,   8'd0,   TMO_POLL));     // at max: overflow
      send_word(pack_req(FN_USIGNAL,   8'd0,   8'd0,   TMO_POLL));     // count to 2
      send_word(pack_req(FN_TWAIT,     8'd7,   8'd7,   TMO_BAD));      // rejected, unit free
      send_word(pack_req(FN_WAIT,      8'd8,   8'd8,   TMO_POLL));     // granted
      send_word(pack_req(FN_TWAIT,     8'd9,   8'd9,   TMO_LONGEST));  // granted
      send_word(pack_req(FN_WAIT,      8'hFF,  8'hFF,  TMO_POLL));     // queued
      send_word(pack_req(FN_TWAIT,     8'd0,   8'd0,   TMO_FOREVER));  // queued
      send_word(pack_req(FN_TWAIT,     8'd1,   8'hFF,  TMO_LONGEST));  // queued
      send_word(pack_req(FN_SIGNAL,    8'd0,   8'd0,   TMO_POLL));     // wakes 255
      send_word(pack_req(FN_USIGNAL,   8'd0,   8'd0,   TMO_POLL));     // wakes 0
      send_word(pack_req(FN_SIGNAL,    8'd0,   8'd0,   TMO_POLL));     // wakes 1
      send_word(pack_req(FN_USIGNAL,   8'd0,   8'd0,   TMO_POLL));     // count to 1

      // random phases under changing settings and idle patterns
      for (p = 0; p < PHASE_COUNT; p++) begin
         if (p < 2) begin
            send_idle_pct = 21;
            recv_idle_pct = 46;
         end else if (p < 4) begin
            send_idle_pct = 46;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_drain();
         case (p)
            0:       apply_setting(16'd0,     16'd1,     1'b1);
            1:       apply_setting(16'd2,     16'd4,     1'b0);
            2:       apply_setting(16'd0,     16'd0,     1'b1);
            3:       apply_setting(16'hFFFF,  16'hFFFF,  1'b0);
            4:       apply_setting(16'hFFFE,  16'hFFFF,  1'b1);
            default: apply_setting(CNT_W'($urandom_range(8)), CNT_W'($urandom_range(8)),
                                   1'($urandom_range(1)));
         endcase
         run_random(PHASE_ITEMS);
      end

      wait_drain();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("counting_semaphore_wait_queue_top_tb passed");
      end else begin
         $display("counting_semaphore_wait_queue_top_tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/csq_pkg.sv
rtl/csq_ctrl.sv
rtl/csq_dp.sv
rtl/counting_semaphore_wait_queue_top.sv
tb/semaphore_result_checker.sv
tb/counting_semaphore_wait_queue_top_tb.sv
